/* hw/rtl/epsl_pkg.sv */
package epsl_pkg;

    // Fixed-point format and accumulator size
    localparam int FRAC_BITS = 16;
    localparam int SUM_WIDTH = 48;

    // Field widths
    localparam int TIME_W  = 64;
    localparam int CNT_W   = 32;
    localparam int SPEED_W = 32;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int DER_W   = ERR_W + 1;
    localparam int GAIN_W  = 16;
    localparam int WIN_W   = 40;
    localparam int LIMIT_W = 12;
    localparam int DUTY_W  = 12;

    // Divider and PID arithmetic widths
    localparam int DIV_W        = 64;
    localparam int DIV_CNT_W    = $clog2(DIV_W);
    localparam int TERM_SAT_EXP = 60;
    localparam int ITERM_W      = TERM_SAT_EXP + 1;
    localparam int PROD_W       = SUM_WIDTH + GAIN_W;
    localparam int PRODX_W      = (PROD_W > ITERM_W) ? PROD_W : ITERM_W;
    localparam int PTERM_W      = GAIN_W + 1 + ERR_W;
    localparam int DTERM_W      = GAIN_W + 1 + DER_W;
    localparam int TOTAL_W      = TERM_SAT_EXP + 2;
    localparam int SHIFT_W      = TOTAL_W - FRAC_BITS;

    // Stream and configuration port widths
    localparam int OUT_FIELDS_W = DUTY_W + SPEED_W + ERR_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 40;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd6;

    // Register reset values
    localparam logic [SPEED_W-1:0] RST_TARGET = 32'd196608;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P = 16'd75;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I = 16'd120;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D = 16'd5;
    localparam logic [WIN_W-1:0]   RST_WINDOW = 40'd1000000000;
    localparam logic [WIN_W-1:0]   RST_RATE   = 40'd100000000;
    localparam logic [LIMIT_W-1:0] RST_LIMIT  = 12'd1024;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic restart;
        logic div_start;
        logic div_sel;
        logic q_save;
        logic speed_en;
        logic err_en;
        logic int_en;
        logic mul_en;
        logic sum_en;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic fire;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } t_stat;

endpackage

/* hw/rtl/epsl_div.sv */
module epsl_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [epsl_pkg::DIV_W-1:0] i_num,
    input  logic [epsl_pkg::DIV_W-1:0] i_den,
    output logic [epsl_pkg::DIV_W-1:0] o_quot,
    output logic                       o_busy,
    output logic                       o_done
);
    import epsl_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_den;
    logic [DIV_W:0]       w_trial;
    logic                 w_fit;

    // Shift in the next numerator bit and try one subtraction
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    // Control: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fit ? DIV_W'(w_trial - {1'b0, r_den}) : w_trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
        end
    end

    assign o_quot = r_quo;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

/* hw/rtl/epsl_dp.sv */
module epsl_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [epsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [epsl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [epsl_pkg::TIME_W-1:0]     i_now,
    input  logic                            i_edge,
    input  epsl_pkg::t_cmd                  i_cmd,
    output epsl_pkg::t_stat                 o_stat,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [epsl_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import epsl_pkg::*;

    // Configuration registers
    logic [SPEED_W-1:0] r_target;
    logic [GAIN_W-1:0]  r_gain_p;
    logic [GAIN_W-1:0]  r_gain_i;
    logic [GAIN_W-1:0]  r_gain_d;
    logic [WIN_W-1:0]   r_window;
    logic [WIN_W-1:0]   r_rate;
    logic [LIMIT_W-1:0] r_limit;

    // Window state
    logic [TIME_W-1:0] r_now;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_win_cnt;
    logic [TIME_W-1:0] r_wstart;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_fire;

    // Divider hookup
    logic [WIN_W-1:0]  w_rate_fix;
    logic [DIV_W-1:0]  w_div_num;
    logic [DIV_W-1:0]  w_div_den;
    logic [DIV_W-1:0]  w_quot;
    logic              w_div_busy;
    logic              w_div_done;
    logic              r_q_zero;

    // Control law
    logic [SPEED_W-1:0]          r_speed;
    logic signed [ERR_W-1:0]     r_err;
    logic signed [ERR_W-1:0]     r_prev;
    logic signed [DER_W-1:0]     r_der;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [SUM_WIDTH-1:0] n_sum;
    logic [SUM_WIDTH:0]          w_sum_wide;
    logic [SUM_WIDTH-1:0]        w_sum_mag;
    logic signed [PTERM_W-1:0]   w_pmul;
    logic signed [DTERM_W-1:0]   w_dmul;
    logic signed [PTERM_W-1:0]   r_pterm;
    logic signed [DTERM_W-1:0]   r_dterm;
    logic [PROD_W-1:0]           r_iprod;
    logic                        r_ineg;
    logic [PRODX_W-1:0]          w_iprodx;
    logic [ITERM_W-1:0]          w_imag;
    logic signed [TOTAL_W-1:0]   w_iterm;
    logic signed [TOTAL_W-1:0]   r_total;
    logic [SHIFT_W-1:0]          w_shift;
    logic [DUTY_W-1:0]           w_duty;

    // Output register
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= RST_TARGET;
            r_gain_p <= RST_GAIN_P;
            r_gain_i <= RST_GAIN_I;
            r_gain_d <= RST_GAIN_D;
            r_window <= RST_WINDOW;
            r_rate   <= RST_RATE;
            r_limit  <= RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET: r_target <= i_cfg_data[SPEED_W-1:0];
                CFG_GAIN_P: r_gain_p <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I: r_gain_i <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D: r_gain_d <= i_cfg_data[GAIN_W-1:0];
                CFG_WINDOW: r_window <= i_cfg_data[WIN_W-1:0];
                CFG_RATE:   r_rate   <= i_cfg_data[WIN_W-1:0];
                CFG_LIMIT:  r_limit  <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Count edges, restart the window when it fires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wstart <= '0;
        end else begin
            if (i_cmd.load && i_edge && (r_count != '1)) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.restart) begin
                r_count  <= '0;
                r_wstart <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_now;
        end
        if (i_cmd.restart) begin
            r_win_cnt <= r_count;
        end
    end

    assign w_elapsed = r_now - r_wstart;
    assign w_fire    = w_elapsed > {{(TIME_W - WIN_W){1'b0}}, r_window};

    // Elapsed / rate first, then scaled count / quotient
    assign w_rate_fix = (r_rate == '0) ? WIN_W'(1) : r_rate;
    assign w_div_num  = i_cmd.div_sel ? DIV_W'({r_win_cnt, {FRAC_BITS{1'b0}}}) : w_elapsed;
    assign w_div_den  = i_cmd.div_sel ? w_quot : DIV_W'(w_rate_fix);

    epsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quot  (w_quot),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done)
    );

    // Saturating error sum
    assign w_sum_wide = {r_sum[SUM_WIDTH-1], r_sum}
                      + {{(SUM_WIDTH + 1 - ERR_W){r_err[ERR_W-1]}}, r_err};
    always_comb begin
        priority if (!w_sum_wide[SUM_WIDTH] && w_sum_wide[SUM_WIDTH-1]) begin
            n_sum = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
        end else if (w_sum_wide[SUM_WIDTH] && !w_sum_wide[SUM_WIDTH-1]) begin
            n_sum = {1'b1, {(SUM_WIDTH - 1){1'b0}}};
        end else begin
            n_sum = w_sum_wide[SUM_WIDTH-1:0];
        end
    end

    assign w_sum_mag = r_sum[SUM_WIDTH-1] ? SUM_WIDTH'(0 - r_sum) : r_sum;
    assign w_pmul    = PTERM_W'($signed({1'b0, r_gain_p})) * PTERM_W'(r_err);
    assign w_dmul    = DTERM_W'($signed({1'b0, r_gain_d})) * DTERM_W'(r_der);

    // Clamp the integral term at the saturation bound
    assign w_iprodx = PRODX_W'(r_iprod);
    assign w_imag   = (w_iprodx > (PRODX_W'(1) << TERM_SAT_EXP))
                    ? (ITERM_W'(1) << TERM_SAT_EXP) : w_iprodx[ITERM_W-1:0];
    assign w_iterm  = r_ineg ? -$signed({1'b0, w_imag}) : $signed({1'b0, w_imag});

    // State that survives across windows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_sum  <= '0;
        end else if (i_cmd.int_en) begin
            r_prev <= r_err;
            r_sum  <= n_sum;
        end
    end

    // Per-window arithmetic pipeline, one step per command
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_save) begin
            r_q_zero <= (w_quot == '0);
        end
        if (i_cmd.speed_en) begin
            priority if (r_q_zero) begin
                r_speed <= (r_win_cnt != '0) ? '1 : '0;
            end else if (w_quot[DIV_W-1:SPEED_W] != '0) begin
                r_speed <= '1;
            end else begin
                r_speed <= w_quot[SPEED_W-1:0];
            end
        end
        if (i_cmd.err_en) begin
            r_err <= $signed({1'b0, r_target}) - $signed({1'b0, r_speed});
        end
        if (i_cmd.int_en) begin
            r_der <= DER_W'(r_err) - DER_W'(r_prev);
        end
        if (i_cmd.mul_en) begin
            r_pterm <= w_pmul;
            r_dterm <= w_dmul;
            r_iprod <= PROD_W'(w_sum_mag) * PROD_W'(r_gain_i);
            r_ineg  <= r_sum[SUM_WIDTH-1];
        end
        if (i_cmd.sum_en) begin
            r_total <= TOTAL_W'(r_pterm) + w_iterm + TOTAL_W'(r_dterm);
        end
    end

    // Shift down and clamp to the duty range
    assign w_shift = SHIFT_W'(r_total >>> FRAC_BITS);
    always_comb begin
        priority if (r_total[TOTAL_W-1] || (r_total == '0)) begin
            w_duty = '0;
        end else if (w_shift > SHIFT_W'(r_limit)) begin
            w_duty = r_limit;
        end else begin
            w_duty = w_shift[DUTY_W-1:0];
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_data <= OUT_DATA_W'({r_err, r_speed, w_duty});
        end
    end

    assign o_stat.fire     = w_fire;
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_busy = r_m_valid;
    assign o_m_tvalid      = r_m_valid;
    assign o_m_tdata       = r_m_data;

endmodule

/* hw/rtl/epsl_ctrl.sv */
module epsl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output epsl_pkg::t_cmd  o_cmd,
    input  epsl_pkg::t_stat i_stat
);
    import epsl_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_DIV2  = 4'd3;
    localparam logic [3:0] S_ERR   = 4'd4;
    localparam logic [3:0] S_INT   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_ready;

    assign w_ready    = i_rst_n && (r_state == S_IDLE);
    assign o_s_tready = w_ready;

    // Sequence one poll through the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && w_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.fire) begin
                    o_cmd.restart   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV1: begin
                if (i_stat.div_done) begin
                    o_cmd.q_save    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = 1'b1;
                    n_state         = S_DIV2;
                end
            end
            S_DIV2: begin
                if (i_stat.div_done) begin
                    o_cmd.speed_en = 1'b1;
                    n_state        = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err_en = 1'b1;
                n_state      = S_INT;
            end
            S_INT: begin
                o_cmd.int_en = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/encoder_pid_speed_loop_core.sv */
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/tready         tdata: now_time; tuser: edge_seen
// m_axis    out  m_axis_tvalid/tready         tdata: pwm_duty, measured_speed, speed_error
// cfg       in   i_cfg_we (no back-pressure)  i_cfg_idx, i_cfg_data
//
// A poll that does not close the window passes through accept and window test only.
// A poll that closes it runs accept, window test, two passes of
// the bit-serial divider (elapsed / rate_unit, then scaled count / quotient, 64 steps
// and a done strobe each) and five steps of error, integral, multiply, sum and load.
// Synchronous active-low reset clears the window state, integral and outputs.
// A waiting result does not block input; the next result stalls in its load step.
module encoder_pid_speed_loop_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [epsl_pkg::TIME_W-1:0]     s_axis_tdata,  // [63:0] now_time
    input  logic                            s_axis_tuser,  // [0] edge_seen
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [11:0] pwm_duty, [43:12] measured_speed, [76:44] speed_error, [79:77] zero
    output logic [epsl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [epsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [epsl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import epsl_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    epsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    epsl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_now      (s_axis_tdata),
        .i_edge     (s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

    // One poll at a time: ready drops right after an accept
    a_one_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("poll accepted while previous poll in progress");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !m_axis_tvalid)
        else $error("result loaded over a pending result");

    // The divider is only started when free
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_stat.div_busy)
        else $error("divider started while busy");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

/* tb/sv/tb_encoder_pid_speed_loop_core.sv */
`timescale 1ns / 1ps

module tb_encoder_pid_speed_loop_core;
    import epsl_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 2000;
    localparam int RAND_BATCHES  = 10;
    localparam int BATCH_ITEMS   = 100;
    localparam longint unsigned MASK40   = 64'hFF_FFFF_FFFF;
    localparam longint unsigned TERM_LIM = 64'd1 << TERM_SAT_EXP;

    typedef struct {
        logic [TIME_W-1:0] now_time;
        logic              edge_seen;
    } t_poll;

    typedef struct {
        logic [DUTY_W-1:0]       pwm_duty;
        logic [SPEED_W-1:0]      measured_speed;
        logic signed [ERR_W-1:0] speed_error;
    } t_duty;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TIME_W-1:0]     s_axis_tdata;   // [63:0] now_time
    logic                  s_axis_tuser;   // [0] edge_seen
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [11:0] pwm_duty, [43:12] measured_speed, [76:44] speed_error, [79:77] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Register copies and loop state of the predictor
    logic [SPEED_W-1:0] cfg_target;
    logic [GAIN_W-1:0]  cfg_kp, cfg_ki, cfg_kd;
    logic [WIN_W-1:0]   cfg_window, cfg_rate;
    logic [LIMIT_W-1:0] cfg_limit;
    logic [CNT_W-1:0]   mdl_count;
    logic [TIME_W-1:0]  mdl_start;
    longint             mdl_prev_err;
    longint             mdl_err_sum;

    t_poll pending_polls[$];
    t_duty duty_expect_q[$];

    bit poll_accepted;
    bit idle_on;
    bit hold_arm;
    bit hold_done;
    int src_gap;
    int sink_gap;
    int hold_left;
    int fail_count;
    int cycle_count;

    encoder_pid_speed_loop_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned rand64();
        return {$urandom, $urandom};
    endfunction

    // Count the edge, and close the window when elapsed time passes its length
    function automatic bit close_window(input t_poll p, output t_duty r);
        longint unsigned elapsed, divisor, quot, speed, mag, prod, duty;
        longint          err, der, iterm, total, sum_hi, sum_lo;
        r = '{default: '0};
        if (p.edge_seen && mdl_count != '1)
            mdl_count = mdl_count + 1'b1;
        elapsed = p.now_time - mdl_start;
        if (elapsed <= 64'(cfg_window))
            return 1'b0;

        // speed = count / floor(elapsed / rate), Q16.16, saturated
        divisor = (cfg_rate == '0) ? 64'd1 : 64'(cfg_rate);
        quot    = elapsed / divisor;
        if (quot == 0) begin
            speed = (mdl_count != '0) ? 64'hFFFF_FFFF : 64'd0;
        end else begin
            speed = (64'(mdl_count) << FRAC_BITS) / quot;
            if (speed > 64'hFFFF_FFFF)
                speed = 64'hFFFF_FFFF;
        end

        // error, derivative and saturating integral
        err          = longint'(64'(cfg_target)) - longint'(speed);
        der          = err - mdl_prev_err;
        mdl_prev_err = err;
        sum_hi       = (longint'(1) << (SUM_WIDTH - 1)) - 1;
        sum_lo       = -sum_hi - 1;
        if (err > 0 && mdl_err_sum > sum_hi - err)
            mdl_err_sum = sum_hi;
        else if (err < 0 && mdl_err_sum < sum_lo - err)
            mdl_err_sum = sum_lo;
        else
            mdl_err_sum = mdl_err_sum + err;

        // integral term clipped in magnitude
        mag = (mdl_err_sum < 0) ? -mdl_err_sum : mdl_err_sum;
        if (cfg_ki == '0 || mag == 0) begin
            iterm = 0;
        end else begin
            if (mag > TERM_LIM / 64'(cfg_ki))
                prod = TERM_LIM;
            else
                prod = mag * 64'(cfg_ki);
            iterm = (mdl_err_sum < 0) ? -longint'(prod) : longint'(prod);
        end

        // PID sum, scale down and clamp to the duty range
        total = longint'(64'(cfg_kp)) * err + iterm + longint'(64'(cfg_kd)) * der;
        if (total <= 0) begin
            duty = 0;
        end else begin
            duty = longint'(total) >> FRAC_BITS;
            if (duty > 64'(cfg_limit))
                duty = 64'(cfg_limit);
        end

        mdl_count = '0;
        mdl_start = p.now_time;
        r.pwm_duty       = duty[DUTY_W-1:0];
        r.measured_speed = speed[SPEED_W-1:0];
        r.speed_error    = err[ERR_W-1:0];
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_TARGET: cfg_target = value[SPEED_W-1:0];
            CFG_GAIN_P: cfg_kp     = value[GAIN_W-1:0];
            CFG_GAIN_I: cfg_ki     = value[GAIN_W-1:0];
            CFG_GAIN_D: cfg_kd     = value[GAIN_W-1:0];
            CFG_WINDOW: cfg_window = value[WIN_W-1:0];
            CFG_RATE:   cfg_rate   = value[WIN_W-1:0];
            CFG_LIMIT:  cfg_limit  = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [SPEED_W-1:0] target,
                            input logic [GAIN_W-1:0] kp, ki, kd,
                            input longint unsigned win, rate,
                            input logic [LIMIT_W-1:0] limit);
        write_reg(CFG_TARGET, 64'(target));
        write_reg(CFG_GAIN_P, 64'(kp));
        write_reg(CFG_GAIN_I, 64'(ki));
        write_reg(CFG_GAIN_D, 64'(kd));
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_RATE, rate);
        write_reg(CFG_LIMIT, 64'(limit));
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 2000));
        endcase
    endfunction

    // Pick a register setting per batch, extremes included
    task automatic random_regs(output longint unsigned win);
        longint unsigned    rate;
        logic [SPEED_W-1:0] target;
        logic [LIMIT_W-1:0] limit;
        case ($urandom_range(0, 9))
            0:       win = MASK40;
            1:       win = 64'd1;
            2, 3:    win = rand64() & MASK40;
            default: win = 64'($urandom_range(1, 3000));
        endcase
        if (win == 0)
            win = 64'd1;
        case ($urandom_range(0, 7))
            0:       rate = MASK40;
            1:       rate = rand64() & MASK40;
            2:       rate = 64'd1;
            default: rate = 64'($urandom_range(1, 400));
        endcase
        case ($urandom_range(0, 5))
            0:       target = '0;
            1:       target = '1;
            2:       target = $urandom;
            default: target = $urandom_range(0, 32'h0010_0000);
        endcase
        case ($urandom_range(0, 4))
            0:       limit = '1;
            1:       limit = 12'd1;
            default: limit = LIMIT_W'($urandom_range(1, 4095));
        endcase
        set_regs(target, pick_gain(), pick_gain(), pick_gain(), win, rate, limit);
    endtask

    task automatic queue_poll(input logic [TIME_W-1:0] t, input logic e);
        pending_polls.push_back('{now_time: t, edge_seen: e});
    endtask

    // Hold until every item is taken and every result is back, then let the core settle
    task automatic wait_idle();
        while (pending_polls.size() != 0 || s_axis_tvalid || duty_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drive polls from the pending queue, with random gaps
    always @(negedge i_clk) begin : poll_driver
        t_poll next_poll;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || poll_accepted) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(0, 14);
                s_axis_tvalid <= 1'b0;
            end else if (pending_polls.size() != 0) begin
                next_poll = pending_polls.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_poll.now_time;
                s_axis_tuser  <= next_poll.edge_seen;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Drive ready with random stalls and one long hold-off
    always @(negedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Predict on each accepted poll, compare each accepted result
    always @(posedge i_clk) begin : duty_check
        t_poll taken;
        t_duty got, want;
        poll_accepted <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            taken.now_time  = s_axis_tdata;
            taken.edge_seen = s_axis_tuser;
            if (close_window(taken, want))
                duty_expect_q.push_back(want);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pwm_duty       = m_axis_tdata[DUTY_W-1:0];
            got.measured_speed = m_axis_tdata[DUTY_W+SPEED_W-1:DUTY_W];
            got.speed_error    = m_axis_tdata[OUT_FIELDS_W-1:DUTY_W+SPEED_W];
            if (duty_expect_q.size() == 0) begin
                $error("unexpected result: pwm_duty %0d measured_speed %0h speed_error %0d",
                       got.pwm_duty, got.measured_speed, got.speed_error);
                fail_count++;
            end else begin
                want = duty_expect_q.pop_front();
                if (got.pwm_duty !== want.pwm_duty) begin
                    $error("pwm_duty: expected %0d, actual %0d", want.pwm_duty, got.pwm_duty);
                    fail_count++;
                end
                if (got.measured_speed !== want.measured_speed) begin
                    $error("measured_speed: expected %0h, actual %0h",
                           want.measured_speed, got.measured_speed);
                    fail_count++;
                end
                if (got.speed_error !== want.speed_error) begin
                    $error("speed_error: expected %0d, actual %0d",
                           want.speed_error, got.speed_error);
                    fail_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        longint unsigned stamp;
        longint unsigned win;
        int              edge_pct;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        idle_on       = 1'b1;
        cfg_target    = RST_TARGET;
        cfg_kp        = RST_GAIN_P;
        cfg_ki        = RST_GAIN_I;
        cfg_kd        = RST_GAIN_D;
        cfg_window    = RST_WINDOW;
        cfg_rate      = RST_RATE;
        cfg_limit     = RST_LIMIT;
        mdl_count     = '0;
        mdl_start     = '0;
        mdl_prev_err  = 0;
        mdl_err_sum   = 0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: window equal to its length stays open, one more ns closes it
        queue_poll(64'd0, 1'b1);
        queue_poll(64'd500_000_000, 1'b1);
        queue_poll(64'd1_000_000_000, 1'b0);
        queue_poll(64'd1_000_000_001, 1'b1);
        wait_idle();

        // Window shorter than rate unit, with and without counted edges
        set_regs(32'h0003_0000, '1, '0, '1, 10, 100, '1);
        queue_poll(64'd1_000_000_020, 1'b1);
        queue_poll(64'd1_000_000_040, 1'b0);
        wait_idle();

        // Zero rate unit and zero duty limit
        set_regs('1, '1, '1, '0, 10, 0, '0);
        queue_poll(64'd1_000_000_041, 1'b1);
        queue_poll(64'd1_000_000_060, 1'b1);
        wait_idle();

        // Largest window and rate unit
        set_regs('0, 16'd1, 16'd1, 16'd1, MASK40, MASK40, 12'd1);
        queue_poll(64'hFFFF_FFFF_FFFF_FFF0, 1'b1);
        wait_idle();

        // Time wrap, timestamp extremes, then an edge burst within one window
        set_regs(32'h0001_0000, 16'd300, 16'd7, 16'd900, 10, 1, '1);
        queue_poll(64'h0000_0000_0000_0005, 1'b1);
        queue_poll(64'h0000_0000_0000_0000, 1'b0);
        queue_poll(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        queue_poll(64'h8000_0000_0000_0000, 1'b1);
        queue_poll(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_poll(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        for (int k = 1; k <= 5; k++)
            queue_poll(64'hAAAA_AAAA_AAAA_AAAA + 64'(k), 1'b1);
        queue_poll(64'hAAAA_AAAA_AAAA_AAB5, 1'b1);
        wait_idle();

        // Random batches: rising timestamps with occasional jumps anywhere
        stamp = rand64();
        for (int b = 0; b < RAND_BATCHES; b++) begin
            random_regs(win);
            idle_on  = (b < RAND_BATCHES - 1) && ($urandom_range(0, 4) != 0);
            edge_pct = $urandom_range(0, 100);
            if (b == 2)
                hold_arm = 1'b1;
            for (int n = 0; n < BATCH_ITEMS; n++) begin
                if ($urandom_range(0, 24) == 0)
                    stamp = rand64();
                else
                    stamp = stamp + rand64() % (win / 3 + 2);
                queue_poll(stamp, $urandom_range(0, 99) < edge_pct);
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
